[hdl/prd_pkg.sv]
package prd_pkg;

  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned THRESH_BITS   = 12;
  localparam int unsigned INTERVAL_BITS = 16;
  localparam int unsigned WARMUP_BITS   = 4;
  localparam int unsigned BPM_BITS      = 16;

  localparam logic [THRESH_BITS-1:0]   THRESHOLD_RESET    = 12'd2200;
  localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RESET = 16'd300;
  localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RESET = 16'd2000;
  localparam logic [WARMUP_BITS-1:0]   WARMUP_RESET       = 4'd5;
  localparam logic [BPM_BITS-1:0]      BPM_NUMERATOR      = 16'd60000;

  // one quotient bit per step
  localparam logic [3:0] DIV_LAST = 4'd15;

  typedef enum logic [1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_MIN_INTERVAL = 2'd1,
    CFG_MAX_INTERVAL = 2'd2,
    CFG_WARMUP_BEATS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } prd_state_e;

endpackage

[hdl/prd_if.sv]
interface prd_in_if #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_ms;

  modport source (output valid, output sample, output time_ms, input ready);
  modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface prd_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] bpm;

  modport source (output valid, output bpm, input ready);
  modport sink   (input valid, input bpm, output ready);
endinterface

[hdl/pulse_rate_detector.sv]
// Pulse rate detector.
// Input channel in_if carries one sensor sample and its millisecond timestamp
// per transaction; output channel out_if carries one BPM value for each beat
// whose interval to the previous beat lies strictly inside the configured
// window. Registers (threshold, min/max interval, warmup beats) are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while
// the block is idle, and the block itself does not enforce this. Writing the
// warmup count also restarts the warmup countdown. A sample that is not a
// measured beat leaves the block idle; a measured beat outside the window
// passes the window check and returns to idle. For a reporting beat the
// acceptance cycle forms the interval, ST_CHECK checks the window, ST_DIV runs
// 16 steps of the bit-serial restoring divider (one quotient bit per cycle),
// ST_DONE loads bpm_q; out_if.valid and in_if.ready then rise together.
// The output register parts the two channels: new samples are taken while a
// result waits. Only if a second result finishes before the first is taken
// does the block hold in its final step until out_if.ready.
// Reset clears the beat history and loads the registers with their defaults.
module pulse_rate_detector
  import prd_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  prd_in_if.sink                   in_if,
  prd_out_if.source                out_if
);

  localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

  logic [THRESH_BITS-1:0]   threshold_q;
  logic [INTERVAL_BITS-1:0] min_int_q;
  logic [INTERVAL_BITS-1:0] max_int_q;

  logic                     above_q;
  logic                     prior_q;
  logic [TIME_BITS-1:0]     last_time_q;
  logic [WARMUP_BITS-1:0]   warm_left_q;

  prd_state_e               state_q, state_d;
  logic [TIME_BITS-1:0]     interval_q;
  logic [INTERVAL_BITS-1:0] div_q;
  logic [INTERVAL_BITS-1:0] rem_q;
  logic [BPM_BITS-1:0]      quo_q;
  logic [3:0]               cnt_q;
  logic                     out_valid_q;
  logic [BPM_BITS-1:0]      bpm_q;

  logic                     in_ready;
  logic                     accept;
  logic [CMP_BITS-1:0]      sample_x;
  logic [CMP_BITS-1:0]      thresh_x;
  logic                     is_beat;
  logic                     is_below;
  logic                     measure;
  logic                     in_window;
  logic                     out_free;
  logic                     div_run;
  logic                     out_load;
  logic [INTERVAL_BITS:0]   rem_shift;
  logic [INTERVAL_BITS+1:0] trial;
  logic                     q_bit;

  assign sample_x = CMP_BITS'(in_if.sample);
  assign thresh_x = CMP_BITS'(threshold_q);
  assign accept   = in_if.valid && in_ready;
  assign is_beat  = (sample_x > thresh_x) && !above_q;
  assign is_below = sample_x < thresh_x;
  assign measure  = is_beat && prior_q && (warm_left_q == '0);

  assign in_window = (interval_q > TIME_BITS'(min_int_q)) &&
                     (interval_q < TIME_BITS'(max_int_q));
  assign out_free  = !out_valid_q || out_if.ready;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_q, quo_q[BPM_BITS-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_q};
  assign q_bit     = !trial[INTERVAL_BITS+1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && measure) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = in_window ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_CHECK: ;
      ST_DIV:   div_run  = 1'b1;
      ST_DONE:  out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      threshold_q <= THRESHOLD_RESET;
      min_int_q   <= MIN_INTERVAL_RESET;
      max_int_q   <= MAX_INTERVAL_RESET;
      above_q     <= 1'b0;
      prior_q     <= 1'b0;
      last_time_q <= '0;
      warm_left_q <= WARMUP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        if (is_beat) begin
          prior_q     <= 1'b1;
          last_time_q <= in_if.time_ms;
          if (prior_q && warm_left_q != '0) warm_left_q <= warm_left_q - 1'b1;
        end
        if (is_beat) begin
          above_q <= 1'b1;
        end else if (is_below) begin
          above_q <= 1'b0;
        end
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD:    threshold_q <= cfg_wdata_i[THRESH_BITS-1:0];
          CFG_MIN_INTERVAL: min_int_q   <= cfg_wdata_i;
          CFG_MAX_INTERVAL: max_int_q   <= cfg_wdata_i;
          CFG_WARMUP_BEATS: warm_left_q <= cfg_wdata_i[WARMUP_BITS-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_CHECK) begin
        cnt_q <= '0;
      end else if (div_run) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (accept && measure) begin
      interval_q <= in_if.time_ms - last_time_q;
    end
    if (state_q == ST_CHECK) begin
      div_q <= interval_q[INTERVAL_BITS-1:0];
      rem_q <= '0;
      quo_q <= BPM_NUMERATOR;
    end else if (div_run) begin
      rem_q <= q_bit ? trial[INTERVAL_BITS-1:0] : rem_shift[INTERVAL_BITS-1:0];
      quo_q <= {quo_q[BPM_BITS-2:0], q_bit};
    end
    if (out_load) begin
      bpm_q <= quo_q;
    end
  end

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid_q;
  assign out_if.bpm   = bpm_q;

  a_div_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != DIV_LAST) |=>
      (state_q == ST_DIV && cnt_q == $past(cnt_q) + 4'd1))
    else $error("divider step count skipped");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("division by zero interval");

  a_check_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> (state_q == ST_IDLE || state_q == ST_DIV))
    else $error("window check left to wrong state");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_if.ready) |=>
      (state_q == ST_DONE && $stable(bpm_q)))
    else $error("result overwrote pending output");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_load) |-> out_valid_q)
    else $error("loaded result not presented");

endmodule
